// ----- src/bis_pkg.sv -----
// Shared types and constants for the bilinear image scaler.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bis_pkg;

    // Fixed field widths.
    localparam int COORD_W    = 16;
    localparam int STEP_W     = 24;
    localparam int SIZE_REG_W = 10;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 32;

    // Queue between the front end and the datapath.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Configuration port.
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd4;

    localparam logic [SIZE_REG_W-1:0] SRC_WIDTH_RESET  = 10'd1;
    localparam logic [SIZE_REG_W-1:0] SRC_HEIGHT_RESET = 10'd1;
    localparam logic [STEP_W-1:0]     STEP_X_RESET     = 24'd65536;
    localparam logic [STEP_W-1:0]     STEP_Y_RESET     = 24'd65536;

    // Item kinds and filter modes.
    localparam logic KIND_WRITE      = 1'b0;
    localparam logic KIND_REQUEST    = 1'b1;
    localparam logic FILTER_NEAREST  = 1'b0;
    localparam logic FILTER_BILINEAR = 1'b1;

    localparam logic FILTER_MODE_RESET = FILTER_BILINEAR;

    typedef struct packed {
        logic                kind;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [CHAN_W-1:0]   in_red;
        logic [CHAN_W-1:0]   in_green;
        logic [CHAN_W-1:0]   in_blue;
        logic [CHAN_W-1:0]   in_alpha;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
    } out_item_t;

    // Control from the mapping stage to the pixel store.
    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [1:0] wr_bank;
    } store_ctl_t;

    // Parities of the two neighbour columns and rows, which pick the banks.
    typedef struct packed {
        logic x_lo_par;
        logic x_hi_par;
        logic y_lo_par;
        logic y_hi_par;
    } nbr_sel_t;

endpackage

`default_nettype wire

// ----- src/bilinear_image_scaler_core.sv -----
// Bilinear image scaler, top level. A request beat passes the queue, the mapping
// stage, the store read register and the blend stages to give its pixel; one beat
// per cycle is sustained while the output is not stalled, set by the four parity
// banks each giving one read per cycle. Writes give no result and use a bank write port.
// rst_n clears the queue, pipeline valids and registers; pixels are not cleared.
`default_nettype none

module bilinear_image_scaler_core #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bis_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [bis_pkg::PDATA_W-1:0]       pwdata,
    output logic [bis_pkg::PDATA_W-1:0]            prdata,
    output logic                                   pready,
    input  wire logic                              item_valid,
    input  wire bis_pkg::in_item_t                 item,
    output logic                                   item_stall,
    output logic                                   result_valid,
    output bis_pkg::out_item_t                     result,
    input  wire logic                              result_stall
);
    import bis_pkg::*;

    localparam int SWX        = $clog2(MAX_WIDTH + 1);
    localparam int SWY        = $clog2(MAX_HEIGHT + 1);
    localparam int HCOLS      = (MAX_WIDTH + 1) / 2;
    localparam int HROWS      = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HCOLS * HROWS;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    logic [SIZE_REG_W-1:0] src_width_reg, src_height_reg;
    logic [STEP_W-1:0]     step_x_reg, step_y_reg;
    logic                  filter_mode_reg;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_idx;

    logic [SWX-1:0]        eff_w;
    logic [SWY-1:0]        eff_h;

    logic                  q_valid, q_pop;
    in_item_t              q_item;
    logic                  blend_ready;
    store_ctl_t            ctl;
    logic [AW-1:0]         wr_addr;
    logic [PIX_W-1:0]      wr_data;
    logic [3:0][AW-1:0]    rd_addr;
    logic [3:0][PIX_W-1:0] rd_data;
    logic [FRAC_BITS-1:0]  frac_x, frac_y;
    nbr_sel_t              sel;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg   <= SRC_WIDTH_RESET;
            src_height_reg  <= SRC_HEIGHT_RESET;
            step_x_reg      <= STEP_X_RESET;
            step_y_reg      <= STEP_Y_RESET;
            filter_mode_reg <= FILTER_MODE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_SRC_WIDTH:   src_width_reg   <= pwdata[SIZE_REG_W-1:0];
                REG_SRC_HEIGHT:  src_height_reg  <= pwdata[SIZE_REG_W-1:0];
                REG_STEP_X:      step_x_reg      <= pwdata[STEP_W-1:0];
                REG_STEP_Y:      step_y_reg      <= pwdata[STEP_W-1:0];
                REG_FILTER_MODE: filter_mode_reg <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_SRC_WIDTH:   prdata = PDATA_W'(src_width_reg);
            REG_SRC_HEIGHT:  prdata = PDATA_W'(src_height_reg);
            REG_STEP_X:      prdata = PDATA_W'(step_x_reg);
            REG_STEP_Y:      prdata = PDATA_W'(step_y_reg);
            REG_FILTER_MODE: prdata = PDATA_W'(filter_mode_reg);
            default:         prdata = '0;
        endcase
    end

    // Effective image size: zero acts as one, too large acts as the maximum.
    always_comb
    begin
        if (src_width_reg == '0)
        begin
            eff_w = SWX'(1);
        end
        else if (16'(src_width_reg) > 16'(MAX_WIDTH))
        begin
            eff_w = SWX'(MAX_WIDTH);
        end
        else
        begin
            eff_w = SWX'(src_width_reg);
        end

        if (src_height_reg == '0)
        begin
            eff_h = SWY'(1);
        end
        else if (16'(src_height_reg) > 16'(MAX_HEIGHT))
        begin
            eff_h = SWY'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = SWY'(src_height_reg);
        end
    end

    bis_front #(
        .SWX (SWX),
        .SWY (SWY)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .eff_w      (eff_w),
        .eff_h      (eff_h),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    bis_map #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS),
        .SWX        (SWX),
        .SWY        (SWY),
        .AW         (AW)
    ) u_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .eff_w       (eff_w),
        .eff_h       (eff_h),
        .step_x      (step_x_reg),
        .step_y      (step_y_reg),
        .filter_mode (filter_mode_reg),
        .down_ready  (blend_ready),
        .ctl         (ctl),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .frac_x      (frac_x),
        .frac_y      (frac_y),
        .sel         (sel)
    );

    bis_store #(
        .AW    (AW),
        .DEPTH (BANK_DEPTH)
    ) u_store (
        .clk     (clk),
        .ctl     (ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bis_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_en        (ctl.rd_en),
        .frac_x       (frac_x),
        .frac_y       (frac_y),
        .sel          (sel),
        .rd_data      (rd_data),
        .ready        (blend_ready),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

    // Nearest mode must hand the blend zero fractions.
    a_nearest_frac: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.rd_en && filter_mode_reg == FILTER_NEAREST) |-> (frac_x == '0 && frac_y == '0))
        else $error("nearest read with non-zero fraction");

    // A live horizontal fraction needs two distinct column banks.
    a_x_banks: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.rd_en && frac_x != '0) |-> (sel.x_lo_par != sel.x_hi_par))
        else $error("horizontal neighbours share a bank");

    // A live vertical fraction needs two distinct row banks.
    a_y_banks: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.rd_en && frac_y != '0) |-> (sel.y_lo_par != sel.y_hi_par))
        else $error("vertical neighbours share a bank");

endmodule

`default_nettype wire

// ----- src/bis_front.sv -----
// Front end of the scaler: accepts beats, drops writes outside the image
// and queues the rest for the datapath. Depends on bis_pkg.
`default_nettype none

module bis_front #(
    parameter int SWX = 10,
    parameter int SWY = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire bis_pkg::in_item_t  item,
    output logic                    item_stall,
    input  wire logic [SWX-1:0]     eff_w,
    input  wire logic [SWY-1:0]     eff_h,
    output logic                    q_valid,
    output bis_pkg::in_item_t       q_item,
    input  wire logic               q_pop
);
    import bis_pkg::*;

    in_item_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                in_range;
    logic                push;

    // Classify: requests always go on, writes only inside the image.
    assign in_range = (item.col < COORD_W'(eff_w)) && (item.row < COORD_W'(eff_h));
    assign push     = item_valid && !item_stall && ((item.kind == KIND_REQUEST) || in_range);

    assign item_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid    = (count_reg != '0);
    assign q_item     = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

// ----- src/bis_map.sv -----
// Coordinate mapping: scales the output position by the step, clamps it to
// the image and forms the four bank addresses, or the write address and data. Depends on bis_pkg.
`default_nettype none

module bis_map #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int FRAC_BITS  = 16,
    parameter int SWX        = 10,
    parameter int SWY        = 10,
    parameter int AW         = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire bis_pkg::in_item_t             q_item,
    output logic                               q_pop,
    input  wire logic [SWX-1:0]                eff_w,
    input  wire logic [SWY-1:0]                eff_h,
    input  wire logic [bis_pkg::STEP_W-1:0]    step_x,
    input  wire logic [bis_pkg::STEP_W-1:0]    step_y,
    input  wire logic                          filter_mode,
    input  wire logic                          down_ready,
    output bis_pkg::store_ctl_t                ctl,
    output logic [AW-1:0]                      wr_addr,
    output logic [bis_pkg::PIX_W-1:0]          wr_data,
    output logic [3:0][AW-1:0]                 rd_addr,
    output logic [FRAC_BITS-1:0]               frac_x,
    output logic [FRAC_BITS-1:0]               frac_y,
    output bis_pkg::nbr_sel_t                  sel
);
    import bis_pkg::*;

    localparam int PW    = COORD_W + STEP_W;
    localparam int IPW   = PW - FRAC_BITS;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int HCOLS = (MAX_WIDTH + 1) / 2;

    logic              valid_reg;
    logic              kind_reg;
    logic [PW-1:0]     pos_x_reg;
    logic [PW-1:0]     pos_y_reg;
    logic [XW-1:0]     wcol_reg;
    logic [YW-1:0]     wrow_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic              ready;

    logic [IPW-1:0]    ip_x, ip_y;
    logic [SWX-1:0]    wm1;
    logic [SWY-1:0]    hm1;
    logic              clamp_x, clamp_y;
    logic [XW-1:0]     x_lo, x_hi;
    logic [YW-1:0]     y_lo, y_hi;

    function automatic logic [AW-1:0] bank_addr(input logic [XW-1:0] x,
                                                 input logic [YW-1:0] y);
        return AW'(32'(y >> 1) * 32'(HCOLS) + 32'(x >> 1));
    endfunction

    assign ready = !valid_reg || down_ready;
    assign q_pop = q_valid && ready;

    // Stage register: product of coordinate and step, or the write payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg  <= q_item.kind;
            pos_x_reg <= PW'(q_item.col) * PW'(step_x);
            pos_y_reg <= PW'(q_item.row) * PW'(step_y);
            wcol_reg  <= q_item.col[XW-1:0];
            wrow_reg  <= q_item.row[YW-1:0];
            pix_reg   <= {q_item.in_alpha, q_item.in_blue, q_item.in_green, q_item.in_red};
        end
    end

    // Clamp the integer parts; a clamped neighbour repeats the last line.
    // Nearest mode uses the low neighbour alone, so both neighbours collapse onto it.
    always_comb
    begin
        ip_x    = pos_x_reg[PW-1:FRAC_BITS];
        ip_y    = pos_y_reg[PW-1:FRAC_BITS];
        wm1     = eff_w - 1'b1;
        hm1     = eff_h - 1'b1;
        clamp_x = (ip_x >= IPW'(wm1));
        clamp_y = (ip_y >= IPW'(hm1));
        x_lo    = clamp_x ? XW'(wm1) : ip_x[XW-1:0];
        y_lo    = clamp_y ? YW'(hm1) : ip_y[YW-1:0];
        x_hi    = (clamp_x || filter_mode == FILTER_NEAREST) ? x_lo : x_lo + 1'b1;
        y_hi    = (clamp_y || filter_mode == FILTER_NEAREST) ? y_lo : y_lo + 1'b1;
        frac_x  = (clamp_x || filter_mode == FILTER_NEAREST) ? '0
                                                              : pos_x_reg[FRAC_BITS-1:0];
        frac_y  = (clamp_y || filter_mode == FILTER_NEAREST) ? '0
                                                              : pos_y_reg[FRAC_BITS-1:0];
    end

    // Each bank takes whichever neighbour has its column and row parity.
    for (genvar b = 0; b < 4; b++)
    begin : g_bank_addr
        logic [XW-1:0] xs;
        logic [YW-1:0] ys;
        assign xs         = (x_lo[0] == b[0]) ? x_lo : x_hi;
        assign ys         = (y_lo[0] == b[1]) ? y_lo : y_hi;
        assign rd_addr[b] = bank_addr(xs, ys);
    end

    assign sel.x_lo_par = x_lo[0];
    assign sel.x_hi_par = x_hi[0];
    assign sel.y_lo_par = y_lo[0];
    assign sel.y_hi_par = y_hi[0];

    assign ctl.wr_en   = valid_reg && (kind_reg == KIND_WRITE) && down_ready;
    assign ctl.rd_en   = valid_reg && (kind_reg == KIND_REQUEST) && down_ready;
    assign ctl.wr_bank = {wrow_reg[0], wcol_reg[0]};
    assign wr_addr     = bank_addr(wcol_reg, wrow_reg);
    assign wr_data     = pix_reg;

endmodule

`default_nettype wire

// ----- src/bis_store.sv -----
// Source pixel store in four banks split by column and row parity, so the
// four neighbours are read together. Depends on bis_pkg.
`default_nettype none

module bis_store #(
    parameter int AW    = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                              clk,
    input  wire bis_pkg::store_ctl_t               ctl,
    input  wire logic [AW-1:0]                     wr_addr,
    input  wire logic [bis_pkg::PIX_W-1:0]         wr_data,
    input  wire logic [3:0][AW-1:0]                rd_addr,
    output logic [3:0][bis_pkg::PIX_W-1:0]         rd_data
);
    import bis_pkg::*;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [PIX_W-1:0] mem [DEPTH];

        // One write port and one registered read port per bank.
        always_ff @(posedge clk)
        begin
            if (ctl.wr_en && (ctl.wr_bank == 2'(b)))
            begin
                mem[wr_addr] <= wr_data;
            end
            if (ctl.rd_en)
            begin
                rd_data[b] <= mem[rd_addr[b]];
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/bis_blend.sv -----
// Blend datapath: weights, per-channel products, sum and saturation,
// ending in the result register. Depends on bis_pkg.
`default_nettype none

module bis_blend #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              rd_en,
    input  wire logic [FRAC_BITS-1:0]              frac_x,
    input  wire logic [FRAC_BITS-1:0]              frac_y,
    input  wire bis_pkg::nbr_sel_t                 sel,
    input  wire logic [3:0][bis_pkg::PIX_W-1:0]    rd_data,
    output logic                                   ready,
    output logic                                   result_valid,
    output bis_pkg::out_item_t                     result,
    input  wire logic                              result_stall
);
    import bis_pkg::*;

    localparam int ONE_W = FRAC_BITS + 1;
    localparam int WW    = 2 * ONE_W;
    localparam int PRW   = WW + CHAN_W;
    localparam int ACCW  = PRW + 2;
    localparam int HW    = ACCW - 2 * FRAC_BITS;
    localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;

    logic en3, en4, en5, en6;

    // Stage 3 sits beside the store's read register.
    logic                 v3_reg;
    logic [FRAC_BITS-1:0] fx3_reg, fy3_reg;
    nbr_sel_t             sel3_reg;

    // Stage 4: weights and selected neighbours.
    logic                        v4_reg;
    logic [3:0][WW-1:0]          w4_reg, w4_next;
    logic [3:0][PIX_W-1:0]       pix4_reg, pix4_next;

    // Stage 5: products per channel and neighbour.
    logic                        v5_reg;
    logic [3:0][3:0][PRW-1:0]    prod5_reg, prod5_next;

    // Stage 6: result register.
    logic                        v6_reg;
    logic [3:0][CHAN_W-1:0]      chan6_reg, chan6_next;

    logic [ONE_W-1:0] gx, gy;
    logic [WW-1:0]    gx_w, gy_w, fx_w, fy_w;

    assign en6   = !v6_reg || !result_stall;
    assign en5   = !v5_reg || en6;
    assign en4   = !v4_reg || en5;
    assign en3   = !v3_reg || en4;
    assign ready = en3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en3)
            begin
                v3_reg <= rd_en;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
            if (en6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    // Weights from the fractions; neighbours picked from the banks.
    always_comb
    begin
        gx   = ONE - ONE_W'(fx3_reg);
        gy   = ONE - ONE_W'(fy3_reg);
        gx_w = WW'(gx);
        gy_w = WW'(gy);
        fx_w = WW'(fx3_reg);
        fy_w = WW'(fy3_reg);
        w4_next[0] = gx_w * gy_w;
        w4_next[1] = gx_w * fy_w;
        w4_next[2] = fx_w * gy_w;
        w4_next[3] = fx_w * fy_w;
        pix4_next[0] = rd_data[{sel3_reg.y_lo_par, sel3_reg.x_lo_par}];
        pix4_next[1] = rd_data[{sel3_reg.y_hi_par, sel3_reg.x_lo_par}];
        pix4_next[2] = rd_data[{sel3_reg.y_lo_par, sel3_reg.x_hi_par}];
        pix4_next[3] = rd_data[{sel3_reg.y_hi_par, sel3_reg.x_hi_par}];
    end

    // Channel value times weight for every channel and neighbour.
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int n = 0; n < 4; n++)
            begin
                prod5_next[c][n] = PRW'(pix4_reg[n][CHAN_W*c +: CHAN_W]) * PRW'(w4_reg[n]);
            end
        end
    end

    // Sum, drop the fraction bits and saturate.
    always_comb
    begin
        logic [ACCW-1:0] acc;
        logic [HW-1:0]   hv;
        for (int c = 0; c < 4; c++)
        begin
            acc = ACCW'(prod5_reg[c][0]) + ACCW'(prod5_reg[c][1])
                + ACCW'(prod5_reg[c][2]) + ACCW'(prod5_reg[c][3]);
            hv  = acc[ACCW-1:2*FRAC_BITS];
            chan6_next[c] = (hv > HW'(255)) ? 8'hFF : hv[CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && rd_en)
        begin
            fx3_reg  <= frac_x;
            fy3_reg  <= frac_y;
            sel3_reg <= sel;
        end
        if (en4)
        begin
            w4_reg   <= w4_next;
            pix4_reg <= pix4_next;
        end
        if (en5)
        begin
            prod5_reg <= prod5_next;
        end
        if (en6)
        begin
            chan6_reg <= chan6_next;
        end
    end

    assign result_valid     = v6_reg;
    assign result.out_red   = chan6_reg[0];
    assign result.out_green = chan6_reg[1];
    assign result.out_blue  = chan6_reg[2];
    assign result.out_alpha = chan6_reg[3];

endmodule

`default_nettype wire

// ----- test/tb_bilinear_image_scaler_core.sv -----
// Self-checking testbench for bilinear_image_scaler_core: directed beats, then
// random pixel writes and requests, checked against a predictor kept in step.
// Depends on bis_pkg and the scaler core; reads no files.
`default_nettype none

module tb_bilinear_image_scaler_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bis_pkg::*;

    localparam int MAX_W      = 512;
    localparam int MAX_H      = 512;
    localparam int FRAC       = 16;
    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 200;
    localparam int QUIET_TAIL = 100;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                item_valid;
    in_item_t            item;
    logic                item_stall;
    logic                result_valid;
    out_item_t           result;
    logic                result_stall;

    bilinear_image_scaler_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item         (item),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

    // Predictor copy of the registers and the pixel store.
    logic [SIZE_REG_W-1:0] width_reg;
    logic [SIZE_REG_W-1:0] height_reg;
    logic [STEP_W-1:0]     step_x_reg;
    logic [STEP_W-1:0]     step_y_reg;
    logic                  mode_reg;
    bit [PIX_W-1:0]        pixel_mem [MAX_W*MAX_H];
    bit                    pixel_known [MAX_W*MAX_H];

    out_item_t expected_pixels[$];
    int        mismatches;
    int        idle_cycles;
    bit        quiet;
    bit        hold_request;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int eff_size(logic [SIZE_REG_W-1:0] v, int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    // Source position of one output coordinate: clamped neighbours and fraction.
    function automatic void map_axis(input longint unsigned coord,
                                     input longint unsigned step,
                                     input int size, output int lo, output int hi,
                                     output longint unsigned frac);
        longint unsigned pos;
        longint unsigned ip;
        pos = coord * step;
        ip  = pos >> FRAC;
        if (ip >= size - 1)
        begin
            lo   = size - 1;
            hi   = size - 1;
            frac = 0;
        end
        else
        begin
            lo   = int'(ip);
            hi   = int'(ip + 1);
            frac = pos & ((64'd1 << FRAC) - 1);
        end
    endfunction

    // Neighbour addresses of a request under the present settings.
    function automatic void neighbours(input logic [COORD_W-1:0] col,
                                       input logic [COORD_W-1:0] row,
                                       output int addr[4], output longint unsigned fx,
                                       output longint unsigned fy);
        int x1, x2, y1, y2;
        map_axis(64'(col), 64'(step_x_reg), eff_size(width_reg, MAX_W), x1, x2, fx);
        map_axis(64'(row), 64'(step_y_reg), eff_size(height_reg, MAX_H), y1, y2, fy);
        addr[0] = y1 * MAX_W + x1;
        addr[1] = y2 * MAX_W + x1;
        addr[2] = y1 * MAX_W + x2;
        addr[3] = y2 * MAX_W + x2;
    endfunction

    // Scaled pixel for one request.
    function automatic out_item_t scaled_pixel(logic [COORD_W-1:0] col,
                                               logic [COORD_W-1:0] row);
        int              addr[4];
        longint unsigned fx, fy, gx, gy, acc;
        longint unsigned wt[4];
        logic [7:0]      chan[4];
        out_item_t       px;
        neighbours(col, row, addr, fx, fy);
        gx = (64'd1 << FRAC) - fx;
        gy = (64'd1 << FRAC) - fy;
        wt[0] = gx * gy;
        wt[1] = gx * fy;
        wt[2] = fx * gy;
        wt[3] = fx * fy;
        for (int c = 0; c < 4; c++)
        begin
            if (mode_reg == FILTER_NEAREST)
                chan[c] = pixel_mem[addr[0]][8*c +: 8];
            else
            begin
                acc = 0;
                for (int n = 0; n < 4; n++)
                    acc += pixel_mem[addr[n]][8*c +: 8] * wt[n];
                acc = acc >> (2 * FRAC);
                chan[c] = (acc > 255) ? 8'd255 : acc[7:0];
            end
        end
        px.out_red   = chan[0];
        px.out_green = chan[1];
        px.out_blue  = chan[2];
        px.out_alpha = chan[3];
        return px;
    endfunction

    // Update the store for an accepted write; returns the result of a request.
    function automatic bit apply_item(in_item_t it, output out_item_t px);
        int a;
        px = '0;
        if (it.kind == KIND_WRITE)
        begin
            if (it.col < eff_size(width_reg, MAX_W) && it.row < eff_size(height_reg, MAX_H))
            begin
                a = it.row * MAX_W + it.col;
                pixel_mem[a]   = {it.in_alpha, it.in_blue, it.in_green, it.in_red};
                pixel_known[a] = 1'b1;
            end
            return 1'b0;
        end
        px = scaled_pixel(it.col, it.row);
        return 1'b1;
    endfunction

    // Offer one beat, hold it until accepted, then predict.
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_px);
        out_item_t px;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        item_valid = 1'b1;
        item       = it;
        do
            @(posedge clk);
        while (item_stall);
        if (apply_item(it, px))
            expected_pixels.push_back(typed ? typed_px : px);
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    // Wait for every expected pixel, then let trailing writes settle.
    task automatic drain();
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = PADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_SRC_WIDTH:   width_reg  = value[SIZE_REG_W-1:0];
            REG_SRC_HEIGHT:  height_reg = value[SIZE_REG_W-1:0];
            REG_STEP_X:      step_x_reg = value[STEP_W-1:0];
            REG_STEP_Y:      step_y_reg = value[STEP_W-1:0];
            REG_FILTER_MODE: mode_reg   = value[0];
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic configure(input int w, input int h, input int sx, input int sy,
                             input logic mode);
        reg_write(REG_SRC_WIDTH, w);
        reg_write(REG_SRC_HEIGHT, h);
        reg_write(REG_STEP_X, sx);
        reg_write(REG_STEP_Y, sy);
        reg_write(REG_FILTER_MODE, {31'd0, mode});
    endtask

    // Random beat: mostly requests over pixels already loaded; a request that
    // would touch an unloaded pixel becomes a write of that pixel instead.
    function automatic in_item_t random_item(int cmax);
        in_item_t        it;
        int              addr[4];
        longint unsigned fx, fy;
        it.in_red   = 8'($urandom);
        it.in_green = 8'($urandom);
        it.in_blue  = 8'($urandom);
        it.in_alpha = 8'($urandom);
        if ($urandom_range(0, 9) < 3)
        begin
            it.kind = KIND_WRITE;
            if ($urandom_range(0, 9) == 0)
            begin
                it.col = 16'($urandom);
                it.row = 16'($urandom);
            end
            else
            begin
                it.col = 16'($urandom_range(0, eff_size(width_reg, MAX_W) + 1));
                it.row = 16'($urandom_range(0, eff_size(height_reg, MAX_H) + 1));
            end
            return it;
        end
        it.kind = KIND_REQUEST;
        if ($urandom_range(0, 7) == 0)
        begin
            it.col = 16'($urandom);
            it.row = 16'($urandom);
        end
        else
        begin
            it.col = 16'($urandom_range(0, cmax));
            it.row = 16'($urandom_range(0, cmax));
        end
        neighbours(it.col, it.row, addr, fx, fy);
        for (int n = 0; n < 4; n++)
        begin
            if (!pixel_known[addr[n]])
            begin
                it.kind = KIND_WRITE;
                it.col  = 16'(addr[n] % MAX_W);
                it.row  = 16'(addr[n] / MAX_W);
                break;
            end
        end
        return it;
    endfunction

    // Result checker and idle watchdog.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else if (result_valid && !result_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %h", result);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (result.out_red !== want.out_red || result.out_green !== want.out_green
                        || result.out_blue !== want.out_blue
                        || result.out_alpha !== want.out_alpha)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pixel mismatch: expected rgba %h, got %h", want, result);
                    end
                end
            end
        end
    end

    // Output stall: random bursts, one long hold on request, none at the tail.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                result_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 1'b0;
                result_stall = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                result_stall = 1'b1;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
            else
            begin
                result_stall = 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
        end
    end

    typedef struct {
        in_item_t  it;
        bit        typed;
        out_item_t px;
    } directed_row_t;

    typedef struct {
        int   w;
        int   h;
        int   sx;
        int   sy;
        logic mode;
        int   cmax;
        int   count;
    } phase_t;

    // Main sequence.
    initial
    begin
        directed_row_t rows[$];
        phase_t        phases[$];
        int            total;
        int            sent;
        out_item_t     none;

        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        item_valid   = 1'b0;
        item         = '0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        mismatches   = 0;
        idle_cycles  = 0;
        none         = '0;
        width_reg    = SRC_WIDTH_RESET;
        height_reg   = SRC_HEIGHT_RESET;
        step_x_reg   = STEP_X_RESET;
        step_y_reg   = STEP_Y_RESET;
        mode_reg     = FILTER_MODE_RESET;

        // Directed beats at reset settings: a one-pixel image, bilinear.
        rows = '{
            '{'{KIND_WRITE,   16'd0,     16'd0,     8'h01, 8'h80, 8'hFE, 8'h7F}, 1'b0, '0},
            '{'{KIND_REQUEST, 16'd0,     16'd0,     8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{8'h01, 8'h80, 8'hFE, 8'h7F}},
            '{'{KIND_WRITE,   16'd1,     16'd0,     8'hAA, 8'hAA, 8'hAA, 8'hAA}, 1'b0, '0},
            '{'{KIND_WRITE,   16'd0,     16'd1,     8'h55, 8'h55, 8'h55, 8'h55}, 1'b0, '0},
            '{'{KIND_WRITE,   16'hFFFF,  16'hFFFF,  8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
            '{'{KIND_REQUEST, 16'hFFFF,  16'hFFFF,  8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
              '{8'h01, 8'h80, 8'hFE, 8'h7F}},
            '{'{KIND_WRITE,   16'd0,     16'd0,     8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
            '{'{KIND_REQUEST, 16'd1,     16'd1,     8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{8'hFF, 8'hFF, 8'hFF, 8'hFF}},
            '{'{KIND_WRITE,   16'd0,     16'd0,     8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
            '{'{KIND_REQUEST, 16'd0,     16'hFFFF,  8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 8'h00}},
            '{'{KIND_REQUEST, 16'hFFFF,  16'd0,     8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
              '{8'h00, 8'h00, 8'h00, 8'h00}}
        };

        // Settings per phase, extremes among them: zero size, oversize, zero
        // and full-scale steps, both filters.
        phases = '{
            '{4,    3,    'h10000,  'h10000,  FILTER_NEAREST,  8,  120},
            '{5,    4,    'h8000,   'h5555,   FILTER_BILINEAR, 10, 130},
            '{0,    0,    'hFFFFFF, 'hFFFFFF, FILTER_BILINEAR, 4,  60},
            '{1023, 1023, 'h4000,   'h2000,   FILTER_BILINEAR, 24, 130},
            '{512,  1,    0,        'hFFFFFF, FILTER_NEAREST,  20, 100},
            '{7,    9,    'h1C71C,  'h9A3F,   FILTER_BILINEAR, 12, 130},
            '{3,    16,   'h18000,  'hC000,   FILTER_BILINEAR, 24, 170}
        };

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_item(rows[i].it, rows[i].typed, rows[i].px);

        total = 0;
        foreach (phases[i])
            total += phases[i].count;
        sent = 0;

        foreach (phases[i])
        begin
            // The sender waits here until every expected pixel has come back.
            drain();
            configure(phases[i].w, phases[i].h, phases[i].sx, phases[i].sy, phases[i].mode);
            if (i == 1)
                hold_request = 1'b1;
            for (int k = 0; k < phases[i].count; k++)
            begin
                quiet = (total - sent) <= QUIET_TAIL;
                send_item(random_item(phases[i].cmax), 1'b0, none);
                sent++;
            end
        end

        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
